### sv/ptd_pkg.sv
// Shared constants and divider interface types for the trial-division factorizer.
`default_nettype none

package ptd_pkg;

  // Width of the value being factored; inputs are zero-extended or truncated to it.
  localparam int NUMBER_BITS = 32;
  // Width of the number and factor ports.
  localparam int FACTOR_BITS = 32;
  // Largest count of results for one number.
  localparam int MAX_RESULTS = 9;
  localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);
  // Step counter width inside the divider.
  localparam int STEP_BITS   = $clog2(NUMBER_BITS);

  typedef struct packed {
    logic                   start;
    logic [NUMBER_BITS-1:0] dividend;
    logic [NUMBER_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [NUMBER_BITS-1:0] quotient;
    logic [NUMBER_BITS-1:0] remainder;
  } div_rsp_t;

endpackage : ptd_pkg

`default_nettype wire

### sv/prime_factorization_trial_division_core.sv
// Top level: trial-division sequencer around a shared serial divider.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | number_i
//   out     | output    | out_valid_o / out_stall_i | factor_o, has_factor_o, last_o
//
// Each trial divisor takes one pass through the serial divider, and each strip of a found
// factor takes one more; a number n needs about sqrt(n) + number of prime powers passes.
// Numbers below two skip the divider and go straight to the no-factor result.
// The divider quotient also serves the loop bound: d <= n / d is checked from it.
// in_stall_o is high from the transfer of a number until its last result is loaded.
// Results sit in an output register, so a stalled output only holds the sequencer
// when another result is ready to load. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module prime_factorization_trial_division_core
  import ptd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [FACTOR_BITS-1:0] number_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [FACTOR_BITS-1:0]      factor_o,
  output logic                        has_factor_o,
  output logic                        last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FOUND,
    ST_FIN
  } state_e;

  state_e                 state_q, state_d;
  logic                   strip_q, strip_d;
  logic [NUMBER_BITS-1:0] n_q, n_d;
  logic [NUMBER_BITS-1:0] d_q, d_d;
  logic [NUMBER_BITS-1:0] pend_q, pend_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [FACTOR_BITS-1:0] factor_q, factor_d;
  logic                   has_factor_q, has_factor_d;
  logic                   last_q, last_d;

  logic                   out_free;
  logic                   tail;
  logic [NUMBER_BITS-1:0] d_next;
  logic [NUMBER_BITS-1:0] n_in;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  ptd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    strip_d      = strip_q;
    n_d          = n_q;
    d_d          = d_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    factor_d     = factor_q;
    has_factor_d = has_factor_q;
    last_d       = last_q;

    div_req.start    = 1'b0;
    div_req.dividend = n_q;
    div_req.divisor  = d_q;

    // The output register can take a new result if it is empty or transferring now.
    out_free = !out_valid_q || !out_stall_i;
    // A cofactor above one left after the trials is itself prime.
    tail     = (n_q > NUMBER_BITS'(1)) && (count_q < COUNT_BITS'(MAX_RESULTS));
    d_next   = d_q + NUMBER_BITS'(1);
    n_in     = NUMBER_BITS'(number_i);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d        = n_in;
          d_d        = NUMBER_BITS'(2);
          count_d    = '0;
          pend_vld_d = 1'b0;
          strip_d    = 1'b0;
          if (n_in < NUMBER_BITS'(2)) begin
            state_d = ST_FIN;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = n_in;
            div_req.divisor  = NUMBER_BITS'(2);
            state_d          = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (!strip_q) begin
            if (count_q == COUNT_BITS'(MAX_RESULTS) || d_q > div_rsp.quotient) begin
              state_d = ST_FIN;
            end else if (div_rsp.remainder == '0) begin
              state_d = ST_FOUND;
            end else begin
              d_d             = d_next;
              div_req.start   = 1'b1;
              div_req.divisor = d_next;
            end
          end else begin
            if (div_rsp.remainder == '0) begin
              n_d              = div_rsp.quotient;
              div_req.start    = 1'b1;
              div_req.dividend = div_rsp.quotient;
            end else begin
              d_d             = d_next;
              strip_d         = 1'b0;
              div_req.start   = 1'b1;
              div_req.divisor = d_next;
            end
          end
        end
      end

      ST_FOUND: begin
        // The previous factor goes out now that a later one is known to follow.
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_valid_d  = 1'b1;
            factor_d     = FACTOR_BITS'(pend_q);
            has_factor_d = 1'b1;
            last_d       = 1'b0;
          end
          pend_d           = d_q;
          pend_vld_d       = 1'b1;
          count_d          = count_q + COUNT_BITS'(1);
          n_d              = div_rsp.quotient;
          strip_d          = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          state_d          = ST_DIV;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (tail && pend_vld_q) begin
            factor_d     = FACTOR_BITS'(pend_q);
            has_factor_d = 1'b1;
            last_d       = 1'b0;
            pend_vld_d   = 1'b0;
          end else if (tail) begin
            factor_d     = FACTOR_BITS'(n_q);
            has_factor_d = 1'b1;
            last_d       = 1'b1;
            state_d      = ST_IDLE;
          end else if (pend_vld_q) begin
            factor_d     = FACTOR_BITS'(pend_q);
            has_factor_d = 1'b1;
            last_d       = 1'b1;
            pend_vld_d   = 1'b0;
            state_d      = ST_IDLE;
          end else begin
            factor_d     = '0;
            has_factor_d = 1'b0;
            last_d       = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      strip_q      <= 1'b0;
      n_q          <= '0;
      d_q          <= '0;
      pend_q       <= '0;
      pend_vld_q   <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      factor_q     <= '0;
      has_factor_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      strip_q      <= strip_d;
      n_q          <= n_d;
      d_q          <= d_d;
      pend_q       <= pend_d;
      pend_vld_q   <= pend_vld_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      factor_q     <= factor_d;
      has_factor_q <= has_factor_d;
      last_q       <= last_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign factor_o     = factor_q;
  assign has_factor_o = has_factor_q;
  assign last_o       = last_q;

endmodule : prime_factorization_trial_division_core

`default_nettype wire

### sv/ptd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, results held until the next start.
`default_nettype none

module ptd_divider
  import ptd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_BITS-1:0]   cnt_q, cnt_d;
  logic [NUMBER_BITS-1:0] rem_q, rem_d;
  logic [NUMBER_BITS-1:0] quo_q, quo_d;
  logic [NUMBER_BITS-1:0] dsr_q, dsr_d;

  logic [NUMBER_BITS:0]   trial;
  logic [NUMBER_BITS:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;

    // The partial remainder stays below the divisor, so one extra bit holds the trial.
    trial = {rem_q, quo_q[NUMBER_BITS-1]};
    diff  = trial - {1'b0, dsr_q};

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[NUMBER_BITS]) begin
        rem_d = diff[NUMBER_BITS-1:0];
        quo_d = {quo_q[NUMBER_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[NUMBER_BITS-1:0];
        quo_d = {quo_q[NUMBER_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + STEP_BITS'(1);
      if (cnt_q == STEP_BITS'(NUMBER_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule : ptd_divider

`default_nettype wire

### sv/ptd_checker.sv
// Port-level checks for the factorizer and the bind that attaches them.
`default_nettype none

module ptd_checker
  import ptd_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic [FACTOR_BITS-1:0] number_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [FACTOR_BITS-1:0] factor_o,
  input wire logic                   has_factor_o,
  input wire logic                   last_o
);

  // A number in work blocks the next one.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a number is still being factored");

  // The block frees its input only once the final result is loaded.
  a_free_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && last_o)
    else $error("input freed without a final result in the output register");

  // The no-factor result is a lone, final, zero result.
  a_no_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_factor_o |-> factor_o == '0 && last_o)
    else $error("no-factor result with nonzero factor or without last");

  a_factor_prime_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_factor_o |-> factor_o > FACTOR_BITS'(1))
    else $error("factor below two");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(factor_o) &&
      $stable(has_factor_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule : ptd_checker

bind prime_factorization_trial_division_core ptd_checker u_ptd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .number_i     (number_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .factor_o     (factor_o),
  .has_factor_o (has_factor_o),
  .last_o       (last_o)
);

`default_nettype wire
